>>> hw/rtl/gpe_pkg.sv
package gpe_pkg;

  // Fixed field widths
  localparam int VAL_W     = 10;
  localparam int CNT_W     = 7;
  localparam int MAX_PAIRS = 64;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  // Flag store access, addresses carried at full value width
  typedef struct packed {
    logic             we;
    logic [VAL_W-1:0] waddr;
    logic             wdata;
    logic [VAL_W-1:0] raddr0;
    logic [VAL_W-1:0] raddr1;
  } ram_req_t;

endpackage

>>> hw/rtl/goldbach_pair_enumerator_top.sv
// Odd, small or oversized targets are answered in the cycle after the transfer.
// Even target n: the flag store is preset, then a sieve runs on the shared adder over
// each candidate p with 2p < n, marking the multiples of every prime p; then pair
// candidates are scanned from n/2 up to n-2, and a closing step ends the result stream.
// Throughput: one target at a time, ready only when idle; result back-pressure stalls the scan.
// Reset (rst_n, synchronous) clears control and output valid; the flag store is not reset.
module goldbach_pair_enumerator_top
  import gpe_pkg::*;
#(
  parameter int MAX_TARGET = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] target
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] larger_prime, [19:10] smaller_prime
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [0] pair_valid, [1] odd_error
  output logic                   out_tlast   // last_pair
);

  ram_req_t         ram_req;
  logic             rd0, rd1;
  logic [VAL_W-1:0] larger_prime, smaller_prime;
  logic             pair_valid, odd_error, last_pair;

  gpe_seq #(.MAX_TARGET(MAX_TARGET)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .target        (in_tdata[VAL_W-1:0]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .larger_prime  (larger_prime),
    .smaller_prime (smaller_prime),
    .pair_valid    (pair_valid),
    .odd_error     (odd_error),
    .last_pair     (last_pair),
    .ram_req       (ram_req),
    .rd0           (rd0),
    .rd1           (rd1)
  );

  gpe_flag_ram #(.DEPTH(MAX_TARGET)) u_ram (
    .clk (clk),
    .req (ram_req),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  assign out_tdata = {(OUT_TDATA_W-2*VAL_W)'(0), smaller_prime, larger_prime};
  assign out_tuser = {odd_error, pair_valid};
  assign out_tlast = last_pair;

endmodule

>>> hw/rtl/gpe_flag_ram.sv
module gpe_flag_ram
  import gpe_pkg::*;
#(
  parameter int DEPTH = 512
) (
  input  logic     clk,
  input  ram_req_t req,
  output logic     rd0,
  output logic     rd1
);

  localparam int AW = $clog2(DEPTH);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rd0 <= mem[req.raddr0[AW-1:0]];
    rd1 <= mem[req.raddr1[AW-1:0]];
  end

endmodule

>>> hw/rtl/gpe_seq.sv
module gpe_seq
  import gpe_pkg::*;
#(
  parameter int MAX_TARGET = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] target,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] larger_prime,
  output logic [VAL_W-1:0] smaller_prime,
  output logic             pair_valid,
  output logic             odd_error,
  output logic             last_pair,
  output ram_req_t         ram_req,
  input  logic             rd0,
  input  logic             rd1
);

  localparam logic [VAL_W:0] MAX_VAL = (VAL_W+1)'(MAX_TARGET);

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_PRD, S_PCHK, S_MARK, S_SRD, S_SCHK, S_FLUSH
  } state_t;

  state_t           state_r;
  logic [VAL_W-1:0] n_r, v_r, p_r, m_r, big_r, small_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_vld_r;
  logic [VAL_W-1:0] pend_big_r, pend_small_r;
  logic             out_vld_r;
  logic [VAL_W-1:0] out_big_r, out_small_r;
  logic             out_pair_r, out_odd_r, out_last_r;

  logic [VAL_W-1:0] add_a, add_b;
  logic [VAL_W:0]   sum;
  logic             out_free, accept, mark_in, found;
  logic             lone_tgt, out_load;

  assign out_free = !out_vld_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign mark_in  = m_r < n_r;
  assign found    = rd0 && rd1;
  assign lone_tgt = target[0] || (target < VAL_W'(4)) || ({1'b0, target} > MAX_VAL);

  // result register is loaded this cycle
  assign out_load = ((state_r == S_IDLE) && accept && lone_tgt)
                 || ((state_r == S_SCHK) && found && pend_vld_r && out_free)
                 || ((state_r == S_FLUSH) && out_free);

  // The one shared adder: doubling p, then stepping through its multiples
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state_r)
      S_PRD, S_PCHK: begin
        add_a = p_r;
        add_b = p_r;
      end
      S_MARK: begin
        add_a = m_r;
        add_b = p_r;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign sum = {1'b0, add_a} + {1'b0, add_b};

  always_comb begin
    ram_req.we     = (state_r == S_FILL) || ((state_r == S_MARK) && mark_in);
    ram_req.waddr  = (state_r == S_FILL) ? v_r : m_r;
    ram_req.wdata  = (state_r == S_FILL) && (v_r >= VAL_W'(2));
    ram_req.raddr0 = ((state_r == S_PRD) || (state_r == S_PCHK)) ? p_r : big_r;
    ram_req.raddr1 = small_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (out_vld_r && out_ready && !out_load) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (lone_tgt) begin
              out_vld_r   <= 1'b1;
              out_big_r   <= '0;
              out_small_r <= '0;
              out_pair_r  <= 1'b0;
              out_odd_r   <= target[0];
              out_last_r  <= 1'b1;
            end else begin
              n_r     <= target;
              v_r     <= '0;
              state_r <= S_FILL;
            end
          end
        end
        S_FILL: begin
          v_r <= v_r + VAL_W'(1);
          if (v_r == n_r - VAL_W'(1)) begin
            p_r     <= VAL_W'(2);
            state_r <= S_PRD;
          end
        end
        S_PRD: begin
          // sieving stops once 2p reaches n
          if (sum >= {1'b0, n_r}) begin
            big_r      <= n_r >> 1;
            small_r    <= n_r >> 1;
            cnt_r      <= '0;
            pend_vld_r <= 1'b0;
            state_r    <= S_SRD;
          end else begin
            state_r <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (rd0) begin
            m_r     <= sum[VAL_W-1:0];
            state_r <= S_MARK;
          end else begin
            p_r     <= p_r + VAL_W'(1);
            state_r <= S_PRD;
          end
        end
        S_MARK: begin
          if (mark_in) begin
            m_r <= sum[VAL_W-1:0];
          end else begin
            p_r     <= p_r + VAL_W'(1);
            state_r <= S_PRD;
          end
        end
        S_SRD: begin
          if ((small_r < VAL_W'(2)) || (cnt_r == CNT_W'(MAX_PAIRS))) begin
            state_r <= S_FLUSH;
          end else begin
            state_r <= S_SCHK;
          end
        end
        S_SCHK: begin
          // a pair is held back one step so the final one can be marked last
          if (!(found && pend_vld_r && !out_free)) begin
            if (found) begin
              if (pend_vld_r) begin
                out_vld_r   <= 1'b1;
                out_big_r   <= pend_big_r;
                out_small_r <= pend_small_r;
                out_pair_r  <= 1'b1;
                out_odd_r   <= 1'b0;
                out_last_r  <= 1'b0;
              end
              pend_vld_r   <= 1'b1;
              pend_big_r   <= big_r;
              pend_small_r <= small_r;
              cnt_r        <= cnt_r + CNT_W'(1);
            end
            big_r   <= big_r + VAL_W'(1);
            small_r <= small_r - VAL_W'(1);
            state_r <= S_SRD;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_vld_r   <= 1'b1;
            out_big_r   <= pend_vld_r ? pend_big_r : '0;
            out_small_r <= pend_vld_r ? pend_small_r : '0;
            out_pair_r  <= pend_vld_r;
            out_odd_r   <= 1'b0;
            out_last_r  <= 1'b1;
            pend_vld_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_vld_r;
  assign larger_prime  = out_big_r;
  assign smaller_prime = out_small_r;
  assign pair_valid    = out_pair_r;
  assign odd_error     = out_odd_r;
  assign last_pair     = out_last_r;

endmodule

>>> hw/rtl/gpe_checker.sv
module gpe_checker
  import gpe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed under back-pressure");

  // odd target: lone error transfer, no pair, zero primes
  a_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0] && (out_tdata == '0))
    else $error("malformed odd-target result");

  // results without a pair are always final and carry zero primes
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == '0))
    else $error("empty result not final");

  // pair ordering: larger prime never below smaller one
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[9:0] >= out_tdata[19:10]) && !out_tuser[1])
    else $error("pair out of order");

  // odd target answered on the next cycle with the error flag
  a_odd_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[0] |=> out_tvalid && out_tuser[1] && out_tlast)
    else $error("odd target not flagged");

endmodule

bind goldbach_pair_enumerator_top gpe_checker u_gpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
